// File: rtl/core/dpts_pkg.sv
// shared types and constants for the dynamic priority task scheduler
// no dependencies

package dpts_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic signed [15:0] PRI_FLOOR = -16'sd100;
  localparam logic signed [15:0] PRI_MIN   = -16'sd32768;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [7:0]         id;
    logic signed [15:0] pri;
    logic [15:0]        rt;
  } slot_t;

endpackage

// File: rtl/core/dynamic_priority_task_scheduler_core.sv
// dynamic priority task scheduler: slot memory, sequential scan, aging write-back
// depends on dpts_pkg
// a load gives no result; busy stays low
// a tick scans every slot in ST_SCAN, one slot memory read per cycle, then drains the
// last read in ST_DRAIN and writes back the chosen slot in ST_UPDATE
// the result strobe comes in the cycle after the write-back, and the next item may start then
// reset clears the ready bits and the control state; slot memory contents are kept

module dynamic_priority_task_scheduler_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic [2:0]         slot_index,
  input  logic [7:0]         task_id,
  input  logic signed [15:0] task_priority,
  input  logic [15:0]        task_runtime,
  output logic               result_valid,
  output logic [2:0]         chosen_slot,
  output logic [7:0]         chosen_id,
  output logic signed [15:0] new_priority,
  output logic [15:0]        runtime_left,
  output logic               task_finished,
  output logic               idle
);
  import dpts_pkg::*;

  slot_t              mem [NUM_SLOTS];
  slot_t              rd_data;
  logic [NUM_SLOTS-1:0] ready;

  state_t             state, state_next;
  logic [SLOT_W-1:0]  cnt;
  logic [SLOT_W-1:0]  cmp_idx;
  logic               cmp_vld;

  logic               best_found;
  logic [SLOT_W-1:0]  best_idx;
  logic [7:0]         best_id;
  logic signed [15:0] best_pri;
  logic [15:0]        best_rt;

  logic               accept;
  logic               load_ok;
  logic               rd_en;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  slot_t              wr_data;
  logic               scan_last;
  logic signed [15:0] thr;
  logic               take;
  logic signed [15:0] np;
  logic [15:0]        nrt;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign load_ok   = (int'(slot_index) < NUM_SLOTS);
  assign scan_last = (cnt == SLOT_W'(NUM_SLOTS - 1));
  assign thr       = best_found ? best_pri : PRI_FLOOR;
  assign take      = cmp_vld && ready[cmp_idx] && (rd_data.pri > thr);
  assign np        = (best_pri == PRI_MIN) ? best_pri : best_pri - 16'sd1;
  assign nrt       = (best_rt != 16'd0) ? best_rt - 16'd1 : best_rt;

  // next state and control
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = SLOT_W'(slot_index);
    wr_data    = '{id: task_id, pri: task_priority, rt: task_runtime};
    case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_TICK) begin
          state_next = ST_SCAN;
        end else if (accept && load_ok) begin
          wr_en = 1'b1;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        wr_en      = best_found;
        wr_addr    = best_idx;
        wr_data    = '{id: best_id, pri: np, rt: nrt};
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[cnt];
    end
  end

  // ready bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= '0;
    end else if (state == ST_IDLE && accept && opcode == OP_LOAD && load_ok) begin
      ready[SLOT_W'(slot_index)] <= (task_runtime != 16'd0);
    end else if (state == ST_UPDATE && best_found) begin
      ready[best_idx] <= (nrt != 16'd0);
    end
  end

  // scan counter and compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= rd_en;
      if (state == ST_IDLE) begin
        cnt <= '0;
      end else if (rd_en) begin
        cnt <= cnt + SLOT_W'(1);
      end
    end
    cmp_idx <= cnt;
  end

  // running best
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (state == ST_IDLE) begin
      best_found <= 1'b0;
    end else if (take) begin
      best_found <= 1'b1;
    end
    if (take) begin
      best_idx <= cmp_idx;
      best_id  <= rd_data.id;
      best_pri <= rd_data.pri;
      best_rt  <= rd_data.rt;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_UPDATE);
    end
    if (state == ST_UPDATE) begin
      if (best_found) begin
        chosen_slot   <= 3'(best_idx);
        chosen_id     <= best_id;
        new_priority  <= np;
        runtime_left  <= nrt;
        task_finished <= (nrt == 16'd0);
        idle          <= 1'b0;
      end else begin
        chosen_slot   <= '0;
        chosen_id     <= '0;
        new_priority  <= '0;
        runtime_left  <= '0;
        task_finished <= 1'b0;
        idle          <= 1'b1;
      end
    end
  end

endmodule

// File: tb/dynamic_priority_task_scheduler_core_tb.sv
// self-checking testbench for the dynamic priority task scheduler core
// tracks the slot table, predicts each dispatch and compares it with the strobed result
// depends on dpts_pkg and dynamic_priority_task_scheduler_core

module dynamic_priority_task_scheduler_core_tb;
  import dpts_pkg::*;

  typedef enum logic [1:0] {
    SLOT_EMPTY,
    SLOT_READY,
    SLOT_DONE
  } slot_status_t;

  typedef struct {
    logic [2:0]         slot;
    logic [7:0]         id;
    logic signed [15:0] pri;
    logic [15:0]        rt;
    logic               fin;
    logic               idle;
  } dispatch_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               opcode = OP_LOAD;
  logic [2:0]         slot_index = '0;
  logic [7:0]         task_id = '0;
  logic signed [15:0] task_priority = '0;
  logic [15:0]        task_runtime = '0;
  logic               result_valid;
  logic [2:0]         chosen_slot;
  logic [7:0]         chosen_id;
  logic signed [15:0] new_priority;
  logic [15:0]        runtime_left;
  logic               task_finished;
  logic               idle;

  logic [7:0]         tbl_id  [NUM_SLOTS];
  logic signed [15:0] tbl_pri [NUM_SLOTS];
  logic [15:0]        tbl_rt  [NUM_SLOTS];
  slot_status_t       tbl_st  [NUM_SLOTS];

  dispatch_t dispatch_q[$];
  int        mismatch_count = 0;
  int        burst_left = 0;

  dynamic_priority_task_scheduler_core DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .slot_index    (slot_index),
    .task_id       (task_id),
    .task_priority (task_priority),
    .task_runtime  (task_runtime),
    .result_valid  (result_valid),
    .chosen_slot   (chosen_slot),
    .chosen_id     (chosen_id),
    .new_priority  (new_priority),
    .runtime_left  (runtime_left),
    .task_finished (task_finished),
    .idle          (idle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("dynamic_priority_task_scheduler_core_tb: errors");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < 40)
      $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic void store_slot(logic [2:0] idx, logic [7:0] id,
                                     logic signed [15:0] pri, logic [15:0] rt);
    if (idx < NUM_SLOTS) begin
      tbl_id[idx]  = id;
      tbl_pri[idx] = pri;
      tbl_rt[idx]  = rt;
      tbl_st[idx]  = (rt == 16'd0) ? SLOT_DONE : SLOT_READY;
    end
  endfunction

  // pick the highest ready priority above the floor, lowest index on a tie, then age it
  function automatic dispatch_t next_dispatch();
    dispatch_t d;
    int        best;
    int        best_pri;
    best = -1;
    best_pri = int'(PRI_FLOOR);
    d = '{slot: '0, id: '0, pri: '0, rt: '0, fin: 1'b0, idle: 1'b1};
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tbl_st[i] == SLOT_READY && int'(tbl_pri[i]) > best_pri) begin
        best_pri = int'(tbl_pri[i]);
        best = i;
      end
    end
    if (best >= 0) begin
      if (tbl_pri[best] != PRI_MIN)
        tbl_pri[best] = tbl_pri[best] - 16'sd1;
      if (tbl_rt[best] != 16'd0)
        tbl_rt[best] = tbl_rt[best] - 16'd1;
      tbl_st[best] = (tbl_rt[best] == 16'd0) ? SLOT_DONE : SLOT_READY;
      d.slot = best[2:0];
      d.id   = tbl_id[best];
      d.pri  = tbl_pri[best];
      d.rt   = tbl_rt[best];
      d.fin  = (tbl_rt[best] == 16'd0);
      d.idle = 1'b0;
    end
    return d;
  endfunction

  // one transaction, preceded by a random gap whenever a burst runs out
  task automatic send_item(opcode_t op, logic [2:0] idx, logic [7:0] id,
                           logic signed [15:0] pri, logic [15:0] rt);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      burst_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 80 : 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start         <= 1'b1;
    opcode        <= op;
    slot_index    <= idx;
    task_id       <= id;
    task_priority <= pri;
    task_runtime  <= rt;
    do @(posedge clk); while (busy !== 1'b0);
    if (op == OP_LOAD)
      store_slot(idx, id, pri, rt);
    else
      dispatch_q.push_back(next_dispatch());
  endtask

  task automatic load_slot(logic [2:0] idx, logic [7:0] id,
                           logic signed [15:0] pri, logic [15:0] rt);
    send_item(OP_LOAD, idx, id, pri, rt);
  endtask

  task automatic tick();
    send_item(OP_TICK, 3'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  always @(posedge clk) begin
    dispatch_t want;
    if (!rst && result_valid === 1'b1) begin
      if (dispatch_q.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(chosen_slot), 32'd0);
      end else begin
        want = dispatch_q.pop_front();
        if (chosen_slot !== want.slot)
          report_mismatch("chosen_slot", 32'(chosen_slot), 32'(want.slot));
        if (chosen_id !== want.id)
          report_mismatch("chosen_id", 32'(chosen_id), 32'(want.id));
        if (new_priority !== want.pri)
          report_mismatch("new_priority", 32'(new_priority), 32'(want.pri));
        if (runtime_left !== want.rt)
          report_mismatch("runtime_left", 32'(runtime_left), 32'(want.rt));
        if (task_finished !== want.fin)
          report_mismatch("task_finished", 32'(task_finished), 32'(want.fin));
        if (idle !== want.idle)
          report_mismatch("idle", 32'(idle), 32'(want.idle));
      end
    end
  end

  task automatic test_empty_table();
    tick();
  endtask

  task automatic test_zero_runtime_load();
    load_slot(3'd0, 8'hFF, 16'sh7FFF, 16'd0);
    tick();
  endtask

  task automatic test_tie_break();
    load_slot(3'd5, 8'h55, 16'sh7FFF, 16'hFFFF);
    load_slot(3'd2, 8'h22, 16'sh7FFF, 16'hFFFF);
    tick();
    tick();
    tick();
    load_slot(3'd2, 8'h22, 16'sh7FFF, 16'd0);
    load_slot(3'd5, 8'h55, 16'sh7FFF, 16'd0);
  endtask

  task automatic test_priority_floor();
    load_slot(3'd7, 8'h00, -16'sd100, 16'd5);
    tick();
    load_slot(3'd6, 8'h01, -16'sd99, 16'd3);
    tick();
    tick();
    load_slot(3'd1, 8'h80, -16'sd32768, 16'd1);
    tick();
  endtask

  task automatic test_run_to_completion();
    load_slot(3'd3, 8'hA5, 16'sd0, 16'd1);
    tick();
    tick();
  endtask

  task automatic test_random_mix(int n_items);
    logic signed [15:0] pri;
    logic [15:0]        rt;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 1) == 0) begin
        tick();
      end else begin
        case ($urandom_range(0, 3))
          0: pri = 16'($urandom);
          1: pri = 16'(-105 + int'($urandom_range(0, 10)));
          2: pri = 16'($urandom_range(0, 3));
          default: pri = 16'(32767 - int'($urandom_range(0, 2)));
        endcase
        case ($urandom_range(0, 9))
          0: rt = 16'd0;
          1, 2, 3: rt = 16'($urandom);
          default: rt = 16'($urandom_range(1, 4));
        endcase
        load_slot(3'($urandom), 8'($urandom), pri, rt);
      end
    end
  endtask

  initial begin
    int guard;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_id[i]  = '0;
      tbl_pri[i] = '0;
      tbl_rt[i]  = '0;
      tbl_st[i]  = SLOT_EMPTY;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_zero_runtime_load();
    test_tie_break();
    test_priority_floor();
    test_run_to_completion();
    test_random_mix(1550);

    start <= 1'b0;
    guard = 0;
    while (dispatch_q.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (dispatch_q.size() != 0)
      report_mismatch("results never seen", 32'(dispatch_q.size()), 32'd0);

    if (mismatch_count == 0)
      $display("dynamic_priority_task_scheduler_core_tb: clean");
    else
      $display("dynamic_priority_task_scheduler_core_tb: errors");
    $finish;
  end

endmodule

// File: dynamic_priority_task_scheduler_core.f
rtl/core/dpts_pkg.sv
rtl/core/dynamic_priority_task_scheduler_core.sv
tb/dynamic_priority_task_scheduler_core_tb.sv
